FILE: sv/gser_pkg.sv
// Shared types and constants for the Gaussian smoother with edge replication.
package gser_pkg;

  // Default filter geometry
  localparam int HALF_TAPS_DEF   = 3;
  localparam int SAMPLE_BITS_DEF = 24;

  // Weight registers
  localparam int NUM_WEIGHTS    = 4;
  localparam int WEIGHT_BITS    = 16;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [WEIGHT_BITS-1:0] WEIGHT_CENTER_RST = 16'hFFFF;
  localparam logic [WEIGHT_BITS-1:0] WEIGHT_SIDE_RST   = 16'h0000;

  // Rounding constant for the Q0.16 product scale
  localparam int ROUND_SHIFT = 16;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_WEIGHT_CENTER     = 2'd0,
    REG_WEIGHT_DIST_ONE   = 2'd1,
    REG_WEIGHT_DIST_TWO   = 2'd2,
    REG_WEIGHT_DIST_THREE = 2'd3
  } gser_reg_t;

  typedef logic [NUM_WEIGHTS-1:0][WEIGHT_BITS-1:0] gser_weights_t;

  // Tag that follows a window through the pipeline
  typedef struct packed {
    logic valid;
    logic last;
  } gser_tag_t;

endpackage

FILE: sv/gser_filter.sv
// Two-stage multiply/accumulate datapath with rounding, saturation and output register.
module gser_filter
  import gser_pkg::*;
#(
  parameter int HALF_TAPS   = HALF_TAPS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  gser_tag_t                                   win_tag,
  input  logic [2*HALF_TAPS:0][SAMPLE_BITS-2:0]       win,
  input  gser_weights_t                               weights,
  output logic                                        win_ready,
  output logic                                        out_valid,
  input  logic                                        out_ready,
  output logic [SAMPLE_BITS-2:0]                      smoothed,
  output logic                                        last_of_line
);

  localparam int NPROD = HALF_TAPS + 1;
  localparam int PW    = WEIGHT_BITS + SAMPLE_BITS;
  localparam int AW    = PW + $clog2(NPROD);
  localparam int RW    = AW - ROUND_SHIFT;
  localparam logic [AW-1:0] ROUND_ADD = AW'(1) << (ROUND_SHIFT - 1);
  localparam logic [RW-1:0] OUT_MAX   =
    {{(RW - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};

  gser_tag_t             p_tag;
  logic [NPROD-1:0][PW-1:0] prod;
  logic [NPROD-1:0][PW-1:0] prod_next;
  logic                  p_en;
  logic                  out_en;
  logic [AW-1:0]         acc;
  logic [AW-1:0]         acc_rnd;
  logic [RW-1:0]         rounded;
  logic [SAMPLE_BITS-2:0] sat;

  assign out_en    = !out_valid || out_ready;
  assign p_en      = !p_tag.valid || out_en;
  assign win_ready = p_en;

  // Tap products: center alone, symmetric taps folded into pair sums
  assign prod_next[0] = PW'(weights[0]) * PW'(win[HALF_TAPS]);
  for (genvar d = 1; d <= HALF_TAPS; d++) begin : g_tap
    logic [SAMPLE_BITS-1:0] pair;
    assign pair = SAMPLE_BITS'(win[HALF_TAPS-d]) + SAMPLE_BITS'(win[HALF_TAPS+d]);
    assign prod_next[d] = PW'(weights[d]) * PW'(pair);
  end

  // Product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      p_tag <= '0;
    end else if (p_en) begin
      p_tag <= win_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (p_en) begin
      prod <= prod_next;
    end
  end

  // Sum, round to nearest (ties up), saturate
  always_comb begin
    acc = '0;
    for (int i = 0; i < NPROD; i++) begin
      acc = acc + AW'(prod[i]);
    end
    acc_rnd = acc + ROUND_ADD;
    rounded = acc_rnd[AW-1:ROUND_SHIFT];
    sat     = (rounded > OUT_MAX) ? OUT_MAX[SAMPLE_BITS-2:0] : rounded[SAMPLE_BITS-2:0];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      last_of_line <= 1'b0;
    end else if (out_en) begin
      out_valid    <= p_tag.valid;
      last_of_line <= p_tag.last;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      smoothed <= sat;
    end
  end

  // Checks
  a_ptag_last_valid: assert property (@(posedge clk) disable iff (rst)
    p_tag.last |-> p_tag.valid)
    else $error("product stage marks last without a valid result");

  a_win_moves_on: assert property (@(posedge clk) disable iff (rst)
    win_ready && win_tag.valid |=> p_tag.valid)
    else $error("window transfer lost in product stage");

  a_out_from_ptag: assert property (@(posedge clk) disable iff (rst)
    p_tag.valid && out_en |=> out_valid && (last_of_line == $past(p_tag.last)))
    else $error("product stage result not moved to output register");

endmodule

FILE: sv/gaussian_smoother_edge_replicate_unit.sv
// Top level of the Gaussian smoother: weights, sample window, line control.
//
// Usage: one line of samples enters on in_valid/in_ready, one sample per
// transfer, with end_of_line set on the last sample of the line. Negative
// samples count as zero. Smoothed samples leave on out_valid/out_ready,
// lagging the input by HALF_TAPS samples; borders replicate the first and
// last sample of the line. last_of_line marks the final result of a line.
// Weights (Q0.16) are written on cfg_valid/cfg_ready, cfg_index 0 = center,
// 1..3 = taps one to three samples away; cfg_ready is always high. Write
// them only while the block is idle.
// Pipeline: a result is formed in the window register by the transfer that
// completes its window, then moves through the product and output registers.
// Throughput: one sample per cycle while in_ready is high. The end_of_line
// sample is followed by HALF_TAPS flush steps that replay the last sample
// through the window; in_ready is low during the flush.
// Reset: weights return to center = 0xFFFF (just below 1.0), others 0; the
// pipeline empties and the next sample starts a new line. A stalled receiver
// holds the output register; the stages in front keep filling until each
// holds a result, then in_ready drops.
module gaussian_smoother_edge_replicate_unit
  import gser_pkg::*;
#(
  parameter int HALF_TAPS   = HALF_TAPS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [SAMPLE_BITS-1:0]    sample,
  input  logic                      end_of_line,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [SAMPLE_BITS-2:0]    smoothed,
  output logic                      last_of_line,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [WEIGHT_BITS-1:0]    cfg_data
);

  localparam int WIN_LEN = 2 * HALF_TAPS + 1;
  localparam int DW      = SAMPLE_BITS - 1;
  localparam int CW      = $clog2(HALF_TAPS + 1);
  localparam logic [CW-1:0] HALF = CW'(HALF_TAPS);
  localparam logic [CW-1:0] ONE  = CW'(1);

  gser_weights_t              weights;
  logic [WIN_LEN-1:0][DW-1:0] win;
  logic [WIN_LEN-1:0][DW-1:0] win_next;
  gser_tag_t                  win_tag;
  logic [CW-1:0]              fill;
  logic [CW-1:0]              fill_inc;
  logic [CW-1:0]              first;
  logic [CW-1:0]              first_next;
  logic [CW-1:0]              kcnt;
  logic                       flushing;
  logic                       win_ready;
  logic                       w_en;
  logic                       accept;
  logic                       flush_step;
  logic [DW-1:0]              samp_clamp;

  // Weight registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      weights[0] <= WEIGHT_CENTER_RST;
      weights[1] <= WEIGHT_SIDE_RST;
      weights[2] <= WEIGHT_SIDE_RST;
      weights[3] <= WEIGHT_SIDE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (gser_reg_t'(cfg_index))
        REG_WEIGHT_CENTER:     weights[0] <= cfg_data;
        REG_WEIGHT_DIST_ONE:   weights[1] <= cfg_data;
        REG_WEIGHT_DIST_TWO:   weights[2] <= cfg_data;
        REG_WEIGHT_DIST_THREE: weights[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake and stage enables
  assign w_en       = !win_tag.valid || win_ready;
  assign in_ready   = w_en && !flushing;
  assign accept     = in_valid && in_ready;
  assign flush_step = flushing && w_en;

  // Negative samples clamp to zero
  assign samp_clamp = sample[SAMPLE_BITS-1] ? '0 : sample[DW-1:0];

  assign fill_inc   = (fill == HALF) ? HALF : fill + ONE;
  assign first_next = HALF - fill_inc + ONE;

  // Window update: fill on line start, shift otherwise, replay last on flush
  always_comb begin
    win_next = win;
    if (accept) begin
      if (fill == '0) begin
        for (int i = 0; i < WIN_LEN; i++) begin
          win_next[i] = samp_clamp;
        end
      end else begin
        for (int i = 0; i < WIN_LEN - 1; i++) begin
          win_next[i] = win[i+1];
        end
        win_next[WIN_LEN-1] = samp_clamp;
      end
    end else if (flush_step) begin
      for (int i = 0; i < WIN_LEN - 1; i++) begin
        win_next[i] = win[i+1];
      end
      win_next[WIN_LEN-1] = win[WIN_LEN-1];
    end
  end

  always_ff @(posedge clk) begin
    win <= win_next;
  end

  // Line control: fill count, flush sequencing, window tag
  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      first    <= '0;
      kcnt     <= '0;
      flushing <= 1'b0;
      win_tag  <= '0;
    end else if (accept) begin
      win_tag.valid <= (fill == HALF);
      win_tag.last  <= 1'b0;
      if (end_of_line) begin
        flushing <= 1'b1;
        kcnt     <= ONE;
        first    <= first_next;
        fill     <= '0;
      end else begin
        fill <= fill_inc;
      end
    end else if (flush_step) begin
      win_tag.valid <= (kcnt >= first);
      win_tag.last  <= (kcnt == HALF);
      kcnt          <= kcnt + ONE;
      if (kcnt == HALF) begin
        flushing <= 1'b0;
      end
    end else if (w_en) begin
      win_tag <= '0;
    end
  end

  gser_filter #(
    .HALF_TAPS   (HALF_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_filter (
    .clk          (clk),
    .rst          (rst),
    .win_tag      (win_tag),
    .win          (win),
    .weights      (weights),
    .win_ready    (win_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .smoothed     (smoothed),
    .last_of_line (last_of_line)
  );

  // Checks
  a_eol_starts_flush: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && end_of_line |=> flushing && (fill == '0))
    else $error("end of line transfer did not start a flush");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= HALF)
    else $error("fill count beyond half window");

  a_last_is_valid: assert property (@(posedge clk) disable iff (rst)
    win_tag.last |-> win_tag.valid && !flushing)
    else $error("last marker without a valid window or with flush pending");

  a_flush_ends_last: assert property (@(posedge clk) disable iff (rst)
    flush_step && (kcnt == HALF) |=> win_tag.last)
    else $error("flush ended without marking the last result");

endmodule

FILE: verif/gaussian_smoother_edge_replicate_unit_tb.sv
// Self-checking testbench for the edge-replicating Gaussian smoother unit.
module gaussian_smoother_edge_replicate_unit_tb
  import gser_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HT       = HALF_TAPS_DEF;
  localparam int SBITS    = SAMPLE_BITS_DEF;
  localparam int WIN      = 2 * HT + 1;
  localparam int IDLE_PCT = 22;

  localparam logic [SBITS-2:0] SMOOTH_MAX = {(SBITS - 1){1'b1}};
  localparam logic [SBITS-1:0] SMP_POS_MAX = {1'b0, {(SBITS - 1){1'b1}}};
  localparam logic [SBITS-1:0] SMP_NEG_MIN = {1'b1, {(SBITS - 1){1'b0}}};
  localparam logic [WEIGHT_BITS-1:0] W_MAX = {WEIGHT_BITS{1'b1}};

  typedef struct packed {
    logic [SBITS-1:0] smp;
    logic             eol;
  } line_item_t;

  typedef struct packed {
    logic [SBITS-2:0] val;
    logic             last;
  } smooth_result_t;

  // DUT connections
  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [SBITS-1:0]          sample = '0;
  logic                      end_of_line = 1'b0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [SBITS-2:0]          smoothed;
  logic                      last_of_line;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = REG_WEIGHT_CENTER;
  logic [WEIGHT_BITS-1:0]    cfg_data = '0;

  // Stimulus and scoreboard storage
  line_item_t     pending_items[$];
  smooth_result_t smoothed_expect[$];

  // Predictor state: weights, clamped sample window, samples seen in the line (capped at HT)
  logic [WEIGHT_BITS-1:0] weight_reg[NUM_WEIGHTS];
  logic [SBITS-2:0]       tap_line[WIN];
  int unsigned            line_fill;

  // Run control and bookkeeping
  bit quiet_mode;
  bit hold_done;
  int hold_left;
  int mismatch_count;
  int results_checked;
  int lines_sent;
  int samples_sent;
  int weight_sets;

  gaussian_smoother_edge_replicate_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample       (sample),
    .end_of_line  (end_of_line),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .smoothed     (smoothed),
    .last_of_line (last_of_line),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Window shift: oldest sample drops out, new one enters at the top
  function automatic void shift_tap(input logic [SBITS-2:0] s);
    for (int i = 0; i < WIN - 1; i++) tap_line[i] = tap_line[i + 1];
    tap_line[WIN - 1] = s;
  endfunction

  // Symmetric FIR around the window center, rounded and saturated
  function automatic logic [SBITS-2:0] filter_window();
    logic [63:0] acc;
    acc = 64'(weight_reg[0]) * 64'(tap_line[HT]);
    for (int d = 1; d <= HT; d++) begin
      acc += 64'(weight_reg[d]) * (64'(tap_line[HT - d]) + 64'(tap_line[HT + d]));
    end
    acc = (acc + (64'd1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
    return (acc > 64'(SMOOTH_MAX)) ? SMOOTH_MAX : acc[SBITS-2:0];
  endfunction

  // Advance the smoother model by one accepted sample, queue its results
  task automatic smooth_step(input line_item_t it);
    logic [SBITS-2:0] clamped;
    int unsigned      prior;
    int unsigned      fill;
    smooth_result_t   res;
    clamped = it.smp[SBITS-1] ? '0 : it.smp[SBITS-2:0];
    prior = line_fill;
    // first sample of a line replicates to the left
    if (prior == 0) begin
      for (int i = 0; i < WIN; i++) tap_line[i] = clamped;
    end else begin
      shift_tap(clamped);
    end
    if (prior >= HT) begin
      res.val  = filter_window();
      res.last = 1'b0;
      smoothed_expect.push_back(res);
    end
    fill = (prior < HT) ? prior + 1 : HT;
    if (it.eol) begin
      // flush: replay the last sample, emit once the center is inside the line
      for (int k = 1; k <= HT; k++) begin
        shift_tap(tap_line[WIN - 1]);
        if (k >= HT - fill + 1) begin
          res.val  = filter_window();
          res.last = (k == HT);
          smoothed_expect.push_back(res);
        end
      end
      line_fill = 0;
    end else begin
      line_fill = fill;
    end
  endtask

  // Sender: offers the queue front, predicts each sample on transfer
  always @(posedge clk) begin : sample_driver
    bit fire;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      fire = in_valid && in_ready;
      if (fire) begin
        smooth_step(pending_items[0]);
        if (pending_items[0].eol) lines_sent++;
        samples_sent++;
        void'(pending_items.pop_front());
      end
      if (!in_valid || fire) begin
        if (pending_items.size() != 0 &&
            (quiet_mode || $urandom_range(99) >= IDLE_PCT)) begin
          in_valid    <= 1'b1;
          sample      <= pending_items[0].smp;
          end_of_line <= pending_items[0].eol;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result transfer against the oldest expectation
  always @(posedge clk) begin : result_monitor
    smooth_result_t exp_res;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (smoothed_expect.size() == 0) begin
          $display("%0t ERROR: unexpected result smoothed=%h last=%b",
                   $realtime, smoothed, last_of_line);
          mismatch_count++;
        end else begin
          exp_res = smoothed_expect.pop_front();
          results_checked++;
          if (smoothed !== exp_res.val) begin
            $display("%0t ERROR: smoothed expected %h actual %h",
                     $realtime, exp_res.val, smoothed);
            mismatch_count++;
          end
          if (last_of_line !== exp_res.last) begin
            $display("%0t ERROR: last_of_line expected %b actual %b",
                     $realtime, exp_res.last, last_of_line);
            mismatch_count++;
          end
        end
      end
      // one long hold-off while the sender has plenty queued
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && pending_items.size() >= 40) begin
        hold_done = 1'b1;
        hold_left = 80;
        out_ready <= 1'b0;
      end else begin
        out_ready <= quiet_mode || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Write all four weights, one transfer each, and mirror them in the model
  task automatic load_weights(input logic [WEIGHT_BITS-1:0] w0, w1, w2, w3);
    gser_reg_t              reg_order[NUM_WEIGHTS];
    logic [WEIGHT_BITS-1:0] vals[NUM_WEIGHTS];
    reg_order = '{REG_WEIGHT_CENTER, REG_WEIGHT_DIST_ONE,
                  REG_WEIGHT_DIST_TWO, REG_WEIGHT_DIST_THREE};
    vals = '{w0, w1, w2, w3};
    for (int i = 0; i < NUM_WEIGHTS; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= reg_order[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      weight_reg[reg_order[i]] = vals[i];
    end
    cfg_valid <= 1'b0;
    weight_sets++;
  endtask

  // Block idle: everything sent, every result back, pipeline settled
  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid || smoothed_expect.size() != 0) begin
      @(posedge clk);
    end
    repeat (10) @(posedge clk);
  endtask

  task automatic push_item(input logic [SBITS-1:0] smp, input logic eol);
    line_item_t it;
    it.smp = smp;
    it.eol = eol;
    pending_items.push_back(it);
  endtask

  function automatic logic [SBITS-1:0] pick_sample();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(9))
      0:       return SMP_POS_MAX;
      1:       return {1'b1, r[SBITS-2:0]};
      2:       return '0;
      3, 4:    return SBITS'(r[11:0]);
      5:       return r[SBITS-1:0];
      default: return {1'b0, r[SBITS-2:0]};
    endcase
  endfunction

  // Mostly mid-length lines, some short ones, a few long ones
  task automatic queue_lines(input int target);
    int queued;
    int len;
    int p;
    queued = 0;
    while (queued < target) begin
      p = $urandom_range(99);
      if (p < 15) len = $urandom_range(HT, 1);
      else if (p < 85) len = $urandom_range(16, HT + 1);
      else len = $urandom_range(40, 17);
      for (int i = 0; i < len; i++) push_item(pick_sample(), i == len - 1);
      queued += len;
    end
  endtask

  initial begin : main_sequence
    logic [WEIGHT_BITS-1:0] wc;
    weight_reg = '{WEIGHT_CENTER_RST, WEIGHT_SIDE_RST, WEIGHT_SIDE_RST, WEIGHT_SIDE_RST};
    for (int i = 0; i < WIN; i++) tap_line[i] = '0;
    line_fill = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset weights (center just below one, sides zero): single, two and three sample lines
    push_item(SMP_POS_MAX, 1'b1);
    push_item(SMP_NEG_MIN, 1'b0);
    push_item(24'h000001, 1'b1);
    push_item(24'h000000, 1'b0);
    push_item(24'hFFFFFF, 1'b0);
    push_item(SMP_POS_MAX, 1'b1);
    wait_idle();

    // Typical bell-shaped weights, extremes and negatives in one line
    load_weights(16'h6000, 16'h3000, 16'h1000, 16'h0800);
    push_item(SMP_POS_MAX, 1'b0);
    push_item(24'h000000, 1'b0);
    push_item(SMP_POS_MAX, 1'b0);
    push_item(24'h01E240, 1'b0);
    push_item(24'hFFFFFB, 1'b0);
    push_item(24'h000001, 1'b0);
    push_item(24'h400000, 1'b0);
    push_item(SMP_POS_MAX, 1'b1);
    wait_idle();

    // Weight sum far above one: saturation
    load_weights(W_MAX, W_MAX, W_MAX, W_MAX);
    push_item(SMP_POS_MAX, 1'b0);
    push_item(24'h100000, 1'b0);
    push_item(24'h000010, 1'b0);
    push_item(SMP_POS_MAX, 1'b1);
    wait_idle();

    // All weights zero
    load_weights('0, '0, '0, '0);
    push_item(24'h123456, 1'b0);
    push_item(SMP_POS_MAX, 1'b1);
    wait_idle();

    // Random lines, center weight 16384..40000 with bounded side weights (this phase also takes the long hold-off)
    wc = 16'($urandom_range(40000, 16384));
    load_weights(wc, 16'($urandom_range((65535 - wc) / 2)),
                 16'($urandom_range(8000)), 16'($urandom_range(4000)));
    queue_lines(65);
    wait_idle();

    // Random lines, arbitrary weights
    load_weights(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    queue_lines(65);
    wait_idle();

    // Center tap off, outer taps at maximum
    load_weights('0, W_MAX, W_MAX, W_MAX);
    queue_lines(65);
    wait_idle();

    // Small random weights at full rate, no idling on either side
    load_weights(16'($urandom_range(4095)), 16'($urandom_range(4095)),
                 16'($urandom_range(4095)), 16'($urandom_range(4095)));
    quiet_mode = 1'b1;
    queue_lines(65);
    wait_idle();
    quiet_mode = 1'b0;

    $display("Covered %0d samples in %0d lines under %0d weight settings plus reset weights,",
             samples_sent, lines_sent, weight_sets);
    $display("checking %0d smoothed results, with one long output stall.", results_checked);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #2_000_000;
    $display("Timeout at %0t", $realtime);
    $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: filelist.f
sv/gser_pkg.sv
sv/gser_filter.sv
sv/gaussian_smoother_edge_replicate_unit.sv
verif/gaussian_smoother_edge_replicate_unit_tb.sv
